>>> rtl/ttsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the transposition table.
// Used by ttsp_ctrl, ttsp_dpath and transposition_table_store_probe.
package ttsp_pkg;

  // Table geometry. The slot count is a power of two by construction.
  localparam int IDX_BITS      = 14;
  localparam int TABLE_ENTRIES = 1 << IDX_BITS;

  // Stored entry layout.
  localparam int SCORE_BITS = 16;
  localparam int DEPTH_BITS = 8;
  localparam int KIND_W     = 2;
  localparam int ENTRY_W    = SCORE_BITS + DEPTH_BITS + KIND_W;

  // Request and result field widths.
  localparam int HASH_W      = 64;
  localparam int PLY_W       = 10;
  localparam int IN_DEPTH_W  = 8;
  localparam int IN_SCORE_W  = 16;
  localparam int WIN_W       = 16;
  localparam int OUT_SCORE_W = 16;
  localparam int THR_W       = 15;

  // Only the upper key bits are kept; the slot index supplies the rest.
  localparam int TAG_W = HASH_W - IDX_BITS;
  localparam int RAM_W = TAG_W + ENTRY_W;

  // Working width for score arithmetic: holds any input score plus or minus a ply.
  localparam int ADJ_W  = ((SCORE_BITS > IN_SCORE_W) ? SCORE_BITS : IN_SCORE_W) + 2;
  // Working width for depth comparisons.
  localparam int DCMP_W = (DEPTH_BITS > IN_DEPTH_W) ? DEPTH_BITS : IN_DEPTH_W;

  localparam logic signed [ADJ_W-1:0] SCORE_HI =
    ADJ_W'((64'd1 << (SCORE_BITS - 1)) - 64'd1);
  localparam logic signed [ADJ_W-1:0] SCORE_LO = -SCORE_HI - ADJ_W'(1);
  localparam logic [DCMP_W-1:0] DEPTH_MAX = DCMP_W'((64'd1 << DEPTH_BITS) - 64'd1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(32000);

  // Command codes.
  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  // Bound kinds.
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIGH  = 2'd2;

  // Configuration register index (paddr bit 2).
  localparam logic REG_MATE_THR = 1'b0;

  // Stream widths.
  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  typedef struct packed {
    logic                    command;
    logic [HASH_W-1:0]       hash;
    logic [PLY_W-1:0]        ply;
    logic [IN_DEPTH_W-1:0]   depth;
    logic [IN_SCORE_W-1:0]   score;
    logic [KIND_W-1:0]       kind;
    logic [WIN_W-1:0]        alpha;
    logic [WIN_W-1:0]        beta;
  } req_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;  // write zeros at the clear pointer and advance it
    logic accept;    // latch the request and start the table read
    logic finish;    // decide, write back and load the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;  // clear pointer sits on the last slot
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

  // Clamp a working-width score into the stored score range.
  function automatic logic signed [ADJ_W-1:0] sat_score(input logic signed [ADJ_W-1:0] v);
    logic signed [ADJ_W-1:0] r;
    r = v;
    if (v > SCORE_HI) r = SCORE_HI;
    if (v < SCORE_LO) r = SCORE_LO;
    return r;
  endfunction

  // Mate test: absolute value at or above the threshold.
  function automatic logic is_mate(input logic signed [ADJ_W-1:0] v,
                                   input logic [THR_W-1:0] thr);
    logic signed [ADJ_W-1:0] a;
    logic signed [ADJ_W-1:0] t;
    a = (v < 0) ? -v : v;
    t = ADJ_W'(thr);
    return a >= t;
  endfunction

endpackage

>>> rtl/ttsp_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ttsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ttsp_ctrl.sv
`timescale 1ns / 1ps
// Sequencing controller: clearing pass after reset, then read and decide cycles.
// Depends on ttsp_pkg.
module ttsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ttsp_pkg::dp_sts_t sts,
  output ttsp_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // Hold here while the previous result is still waiting downstream.
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/ttsp_dpath.sv
`timescale 1ns / 1ps
// Datapath: table RAM, clear pointer, request latch, store/probe decision, result register.
// Depends on ttsp_pkg and ttsp_ram.
module ttsp_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ttsp_pkg::dp_cmd_t                     cmd,
  output ttsp_pkg::dp_sts_t                     sts,
  input  ttsp_pkg::req_t                        req,
  input  logic [ttsp_pkg::THR_W-1:0]            mate_thr,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ttsp_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [ttsp_pkg::OUT_USER_W-1:0]       out_tuser
);

  localparam int AW = ttsp_pkg::IDX_BITS;
  localparam int SW = ttsp_pkg::ADJ_W;
  localparam int DW = ttsp_pkg::DCMP_W;

  // Clear pointer.
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Request latch.
  ttsp_pkg::req_t req_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= req;
    end
  end

  // Table RAM: tag above the entry (kind, depth, score from the top down).
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ttsp_pkg::RAM_W-1:0] ram_wdata;
  logic [ttsp_pkg::RAM_W-1:0] ram_rdata;

  ttsp_ram #(
    .WIDTH (ttsp_pkg::RAM_W),
    .DEPTH (ttsp_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (req.hash[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Fields of the slot just read.
  logic                              e_vld;
  logic [ttsp_pkg::TAG_W-1:0]        e_tag;
  logic [ttsp_pkg::KIND_W-1:0]       e_kind;
  logic [ttsp_pkg::DEPTH_BITS-1:0]   e_depth;
  logic signed [ttsp_pkg::SCORE_BITS-1:0] e_score;

  assign e_score = ram_rdata[ttsp_pkg::SCORE_BITS-1:0];
  assign e_depth = ram_rdata[ttsp_pkg::SCORE_BITS +: ttsp_pkg::DEPTH_BITS];
  assign e_kind  = ram_rdata[ttsp_pkg::SCORE_BITS + ttsp_pkg::DEPTH_BITS +: ttsp_pkg::KIND_W];
  assign e_tag   = ram_rdata[ttsp_pkg::ENTRY_W +: ttsp_pkg::TAG_W];
  assign e_vld   = (e_depth != '0);

  // Request fields in working widths.
  logic signed [SW-1:0] ply_x;
  logic signed [SW-1:0] in_score_x;
  logic signed [SW-1:0] alpha_x;
  logic signed [SW-1:0] beta_x;
  logic [DW-1:0]        req_depth_x;

  assign ply_x       = SW'(req_r.ply);
  assign in_score_x  = SW'(signed'(req_r.score));
  assign alpha_x     = SW'(signed'(req_r.alpha));
  assign beta_x      = SW'(signed'(req_r.beta));
  assign req_depth_x = DW'(req_r.depth);

  // Store path: mate scores move away from zero by the ply and get full depth.
  logic signed [SW-1:0] st_in;
  logic signed [SW-1:0] st_adj;
  logic signed [SW-1:0] st_score;
  logic                 st_mate;
  logic [DW-1:0]        st_depth;
  logic                 do_write;

  always_comb begin
    st_in    = ttsp_pkg::sat_score(in_score_x);
    st_mate  = ttsp_pkg::is_mate(st_in, mate_thr);
    st_adj   = (st_in > 0) ? st_in + ply_x : st_in - ply_x;
    st_score = st_mate ? ttsp_pkg::sat_score(st_adj) : st_in;
    if (st_mate || (req_depth_x > ttsp_pkg::DEPTH_MAX)) begin
      st_depth = ttsp_pkg::DEPTH_MAX;
    end else begin
      st_depth = req_depth_x;
    end
    do_write = (st_depth > DW'(e_depth));
  end

  // Probe path: mate scores move back toward zero, then the bound test.
  logic signed [SW-1:0] pr_raw;
  logic signed [SW-1:0] pr_adj;
  logic signed [SW-1:0] pr_score;
  logic                 pr_bound_ok;
  logic                 pr_hit;

  always_comb begin
    pr_raw   = SW'(e_score);
    pr_adj   = (pr_raw > 0) ? pr_raw - ply_x : pr_raw + ply_x;
    pr_score = ttsp_pkg::is_mate(pr_raw, mate_thr) ? ttsp_pkg::sat_score(pr_adj) : pr_raw;
    unique case (e_kind)
      ttsp_pkg::KIND_EXACT: pr_bound_ok = 1'b1;
      ttsp_pkg::KIND_LOW:   pr_bound_ok = (pr_score <= alpha_x);
      ttsp_pkg::KIND_HIGH:  pr_bound_ok = (pr_score >= beta_x);
      default:              pr_bound_ok = 1'b0;
    endcase
    pr_hit = (e_tag == req_r.hash[ttsp_pkg::HASH_W-1:AW]) && e_vld &&
             (DW'(e_depth) >= req_depth_x) && pr_bound_ok;
  end

  logic is_store;
  assign is_store = (req_r.command == ttsp_pkg::CMD_STORE);

  // RAM write: clearing pass or a replacing store.
  always_comb begin
    ram_we    = cmd.clr_step || (cmd.finish && is_store && do_write);
    ram_waddr = cmd.clr_step ? clr_cnt_r : req_r.hash[AW-1:0];
    if (cmd.clr_step) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {req_r.hash[ttsp_pkg::HASH_W-1:AW], req_r.kind,
                   st_depth[ttsp_pkg::DEPTH_BITS-1:0],
                   st_score[ttsp_pkg::SCORE_BITS-1:0]};
    end
  end

  // Result register.
  logic                              out_valid_r;
  logic                              hit_r;
  logic                              written_r;
  logic [ttsp_pkg::OUT_SCORE_W-1:0]  found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit_r     <= !is_store && pr_hit;
      written_r <= is_store && do_write;
      found_r   <= (!is_store && pr_hit) ? pr_score[ttsp_pkg::OUT_SCORE_W-1:0] : '0;
    end
  end

  assign sts.clr_last = (clr_cnt_r == AW'(ttsp_pkg::TABLE_ENTRIES - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = found_r;
  assign out_tuser  = {written_r, hit_r};

endmodule

>>> rtl/transposition_table_store_probe.sv
`timescale 1ns / 1ps
// Top level of the depth-preferred transposition table: stream ports, APB register.
// Depends on ttsp_pkg, ttsp_ctrl, ttsp_dpath (which holds ttsp_ram).

// A direct-mapped table of 16384 search results, indexed by the low 14 bits of the
// position key. Each request is either a store or a probe and produces exactly one
// result. One request is worked on at a time: the table RAM read comes first, then
// the decision, write-back and load of the result register, and no new request is
// taken before the last one has finished its decide step. The result register holds
// one finished result, so the next request is accepted while that result still
// waits; a second result waits in the decide cycle until the first one has been
// taken. After reset the block runs a clearing pass that zeroes every slot, one per
// cycle, and accepts no request until it is done; the mate threshold register can
// be written at any time, but should only be changed while no request is outstanding.
module transposition_table_store_probe (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // hash[63:0], ply[73:64], depth[81:74], score[97:82], bound_kind[99:98],
  // alpha[115:100], beta[131:116], zero padding[135:132]
  input  logic [ttsp_pkg::IN_DATA_W-1:0]      in_tdata,
  // command[0]
  input  logic [ttsp_pkg::IN_USER_W-1:0]      in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found_score[15:0]
  output logic [ttsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // hit[0], written[1]
  output logic [ttsp_pkg::OUT_USER_W-1:0]     out_tuser,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ttsp_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [ttsp_pkg::APB_DW-1:0]         cfg_pwdata,
  output logic [ttsp_pkg::APB_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  // The only register, mate_threshold, lives at byte address 0. Address bit 2
  // selects the register word; anything above the list reads as zero and ignores writes.
  logic [ttsp_pkg::THR_W-1:0] mate_thr_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_thr_r <= ttsp_pkg::THR_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == ttsp_pkg::REG_MATE_THR)) begin
      mate_thr_r <= cfg_pwdata[ttsp_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == ttsp_pkg::REG_MATE_THR) begin
      cfg_prdata = ttsp_pkg::APB_DW'(mate_thr_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  // Unpack the request word into its fields.
  ttsp_pkg::req_t req;

  assign req.command = in_tuser[0];
  assign req.hash    = in_tdata[63:0];
  assign req.ply     = in_tdata[73:64];
  assign req.depth   = in_tdata[81:74];
  assign req.score   = in_tdata[97:82];
  assign req.kind    = in_tdata[99:98];
  assign req.alpha   = in_tdata[115:100];
  assign req.beta    = in_tdata[131:116];

  ttsp_pkg::dp_cmd_t cmd;
  ttsp_pkg::dp_sts_t sts;

  ttsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ttsp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req        (req),
    .mate_thr   (mate_thr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // Only one request is in flight, so the cycle after an accept is never ready.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // The clearing pass starts at reset, so nothing is accepted right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready right after reset");

  // A result is either a probe result or a store result, never both.
  a_hit_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result flags both hit and written");

  // A miss or a store reports a zero score.
  a_miss_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("nonzero score without a hit");

  // The controller issues at most one datapath command per cycle.
  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.accept, cmd.finish}))
    else $error("conflicting datapath commands");
`endif

endmodule

>>> test/ttsp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the transposition table: follows the request, result and
// register ports, predicts every result and compares it. Depends on ttsp_pkg.
module ttsp_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [ttsp_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [ttsp_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [ttsp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic [ttsp_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [ttsp_pkg::APB_AW-1:0]         cfg_paddr,
  input  logic [ttsp_pkg::APB_DW-1:0]         cfg_pwdata,
  input  logic [ttsp_pkg::APB_DW-1:0]         cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  err_count,
  output int                                  pending,
  output int                                  hit_count,
  output int                                  write_count
);
  import ttsp_pkg::*;

  localparam int OFF_PLY   = HASH_W;
  localparam int OFF_DEPTH = OFF_PLY + PLY_W;
  localparam int OFF_SCORE = OFF_DEPTH + IN_DEPTH_W;
  localparam int OFF_KIND  = OFF_SCORE + IN_SCORE_W;
  localparam int OFF_ALPHA = OFF_KIND + KIND_W;
  localparam int OFF_BETA  = OFF_ALPHA + WIN_W;

  typedef struct packed {
    logic                   hit;
    logic [OUT_SCORE_W-1:0] found_score;
    logic                   written;
  } probe_outcome_t;

  logic [HASH_W-1:0]  key_mem   [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] entry_mem [TABLE_ENTRIES];
  logic [THR_W-1:0]   mate_thr;
  probe_outcome_t     outcome_q [$];
  int                 errs;
  int                 hits;
  int                 writes;

  function automatic int clip_score(input int v);
    int hi;
    int lo;
    hi = (1 << (SCORE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic logic mate_like(input int v);
    return ((v < 0) ? -v : v) >= int'(mate_thr);
  endfunction

  // Applies one request to the shadow table and returns what the block must answer.
  function automatic probe_outcome_t apply_request(input req_t r);
    probe_outcome_t        res;
    logic [IDX_BITS-1:0]   slot;
    logic [ENTRY_W-1:0]    ent;
    logic [DEPTH_BITS-1:0] held_depth;
    logic [DEPTH_BITS-1:0] new_depth;
    logic [KIND_W-1:0]     held_kind;
    int                    sc;
    int                    ply;
    logic                  usable;
    res = '0;
    slot = r.hash[IDX_BITS-1:0];
    ent = entry_mem[slot];
    held_depth = ent[SCORE_BITS +: DEPTH_BITS];
    held_kind = ent[SCORE_BITS + DEPTH_BITS +: KIND_W];
    ply = int'(r.ply);
    if (r.command == CMD_STORE) begin
      sc = clip_score(int'($signed(r.score)));
      new_depth = r.depth;
      // Mate scores are made root-relative and pinned at the deepest depth.
      if (mate_like(sc)) begin
        sc = clip_score((sc > 0) ? sc + ply : sc - ply);
        new_depth = '1;
      end
      if (new_depth > held_depth) begin
        key_mem[slot] = r.hash;
        entry_mem[slot] = {r.kind, new_depth, SCORE_BITS'(sc)};
        res.written = 1'b1;
      end
    end else if (key_mem[slot] == r.hash && held_depth != 0 && held_depth >= r.depth) begin
      sc = int'($signed(ent[SCORE_BITS-1:0]));
      if (mate_like(sc)) begin
        sc = clip_score((sc > 0) ? sc - ply : sc + ply);
      end
      case (held_kind)
        KIND_EXACT: usable = 1'b1;
        KIND_LOW:   usable = (sc <= int'($signed(r.alpha)));
        KIND_HIGH:  usable = (sc >= int'($signed(r.beta)));
        default:    usable = 1'b0;
      endcase
      if (usable) begin
        res.hit = 1'b1;
        res.found_score = OUT_SCORE_W'(sc);
      end
    end
    return res;
  endfunction

  task automatic report(input string what, input int want, input int got);
    errs++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    req_t           r;
    probe_outcome_t got;
    probe_outcome_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        key_mem[i] = '0;
        entry_mem[i] = '0;
      end
      mate_thr = THR_RESET;
      outcome_q.delete();
      errs = 0;
      hits = 0;
      writes = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser[0];
        got.written = out_tuser[1];
        got.found_score = out_tdata;
        if (outcome_q.size() == 0) begin
          errs++;
          $display("%0t: result with nothing outstanding, expected none, %s %0b %0d %0b",
                   $time, "got hit, score, written", got.hit, $signed(got.found_score),
                   got.written);
        end else begin
          want = outcome_q.pop_front();
          if (got.hit !== want.hit) report("hit", want.hit, got.hit);
          if (got.found_score !== want.found_score) begin
            report("found_score", $signed(want.found_score), $signed(got.found_score));
          end
          if (got.written !== want.written) report("written", want.written, got.written);
        end
      end
      if (in_tvalid && in_tready) begin
        r.command = in_tuser[0];
        r.hash    = in_tdata[0 +: HASH_W];
        r.ply     = in_tdata[OFF_PLY +: PLY_W];
        r.depth   = in_tdata[OFF_DEPTH +: IN_DEPTH_W];
        r.score   = in_tdata[OFF_SCORE +: IN_SCORE_W];
        r.kind    = in_tdata[OFF_KIND +: KIND_W];
        r.alpha   = in_tdata[OFF_ALPHA +: WIN_W];
        r.beta    = in_tdata[OFF_BETA +: WIN_W];
        want = apply_request(r);
        if (want.hit) hits++;
        if (want.written) writes++;
        outcome_q.push_back(want);
      end
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_MATE_THR) begin
        if (cfg_pwrite) begin
          mate_thr = cfg_pwdata[THR_W-1:0];
        end else if (cfg_prdata !== APB_DW'(mate_thr)) begin
          report("mate_threshold readback", mate_thr, cfg_prdata);
        end
      end
    end
    err_count   <= errs;
    pending     <= outcome_q.size();
    hit_count   <= hits;
    write_count <= writes;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for transposition_table_store_probe: clock, reset,
// request and register stimulus, verdict. Depends on ttsp_pkg and ttsp_result_checker.
module tb;
  import ttsp_pkg::*;

  // Field offsets inside in_tdata, lowest field first.
  localparam int OFF_PLY   = HASH_W;
  localparam int OFF_DEPTH = OFF_PLY + PLY_W;
  localparam int OFF_SCORE = OFF_DEPTH + IN_DEPTH_W;
  localparam int OFF_KIND  = OFF_SCORE + IN_SCORE_W;
  localparam int OFF_ALPHA = OFF_KIND + KIND_W;
  localparam int OFF_BETA  = OFF_ALPHA + WIN_W;

  // A generous limit that covers the clearing pass and the rest of the run, even
  // with long gaps and stalls.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 180;
  localparam int POOL_KEYS = 24;
  localparam int POOL_SLOTS = 8;
  localparam int SCORE_TOP = 32767;
  localparam int SCORE_BOTTOM = -32768;

  // Keys for the directed part. KEY_A2 shares the slot of KEY_A with another tag.
  localparam logic [HASH_W-1:0] KEY_A  = 64'h0123_4567_89AB_C005;
  localparam logic [HASH_W-1:0] KEY_A2 = KEY_A ^ 64'h0000_0100_0000_0000;
  localparam logic [HASH_W-1:0] KEY_B  = 64'h1111_2222_3333_0444;
  localparam logic [HASH_W-1:0] KEY_C  = 64'h8000_0000_0000_1001;
  localparam logic [HASH_W-1:0] KEY_D  = 64'h7FFF_FFFF_FFFF_2002;
  localparam logic [HASH_W-1:0] KEY_E  = 64'hDEAD_BEEF_0000_3003;
  localparam logic [HASH_W-1:0] KEY_F  = 64'hCAFE_F00D_0000_0606;
  localparam logic [HASH_W-1:0] KEY_G  = 64'h0F0F_0F0F_0F0F_0707;
  localparam logic [HASH_W-1:0] KEY_H  = 64'h5555_AAAA_5555_0808;
  localparam logic [HASH_W-1:0] KEY_Z  = 64'h2468_ACE0_1357_0909;
  localparam logic [HASH_W-1:0] KEY_ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_AW-1:0]     cfg_paddr = '0;
  logic [APB_DW-1:0]     cfg_pwdata = '0;
  logic [APB_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  int chk_errors;
  int chk_pending;
  int chk_hits;
  int chk_writes;

  // Stimulus bookkeeping. cur_thr only shapes scores toward the mate boundary.
  int             cycle_count = 0;
  int             burst_left = 4;
  int             n_stores = 0;
  int             n_probes = 0;
  int             n_settings = 1;
  logic [THR_W-1:0] cur_thr = THR_RESET;

  // Receiver state: a stall mode, a countdown to its next redraw, and a tick count.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  always #5 clk = ~clk;

  transposition_table_store_probe dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The checker sees exactly the pins the block sees and reports back only counts.
  ttsp_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .err_count   (chk_errors),
    .pending     (chk_pending),
    .hit_count   (chk_hits),
    .write_count (chk_writes)
  );

  // Watchdog. Any hang, including a block that never leaves its clearing pass,
  // ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit with %0d results outstanding",
               $time, chk_pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side back-pressure. Modes: always ready, coin flip, mostly stalled,
  // and a regular one-in-five stall, so stalls fall in every phase of a request.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left = rx_left - 1;
    end
    rx_tick = rx_tick + 1;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_tick % 5) != 4);
    endcase
  end

  // Presents one request and holds it until the block takes it. Called just after
  // a rising edge. Valid stays high across a burst; between bursts it drops for a
  // random gap, and now and then a long burst runs with no gap at all.
  task automatic send_req(input logic cmd, input logic [HASH_W-1:0] key, input int ply,
                          input int depth, input int score, input logic [KIND_W-1:0] kind,
                          input int alpha, input int beta);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[0 +: HASH_W]            = key;
    d[OFF_PLY +: PLY_W]       = PLY_W'(ply);
    d[OFF_DEPTH +: IN_DEPTH_W] = IN_DEPTH_W'(depth);
    d[OFF_SCORE +: IN_SCORE_W] = IN_SCORE_W'(score);
    d[OFF_KIND +: KIND_W]     = kind;
    d[OFF_ALPHA +: WIN_W]     = WIN_W'(alpha);
    d[OFF_BETA +: WIN_W]      = WIN_W'(beta);
    in_tdata  <= d;
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_STORE) n_stores++;
    else n_probes++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  // Drains the block: valid goes low, every predicted result must come back, and
  // a short pause covers the decide cycle before the register may change.
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (chk_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes the mate threshold and reads it back in a back-to-back transfer.
  task automatic write_threshold(input logic [APB_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_MATE_THR, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_thr = value[THR_W-1:0];
    n_settings++;
  endtask

  // Scores spread over the full range, the edges of the range, small values, and
  // values just around plus and minus the current mate threshold.
  function automatic int pick_score;
    int s;
    case ($urandom_range(0, 5))
      0:       s = int'($signed(16'($urandom)));
      1:       s = int'(cur_thr) + int'($urandom_range(0, 6)) - 3;
      2:       s = -int'(cur_thr) + int'($urandom_range(0, 6)) - 3;
      3, 4:    s = int'($urandom_range(0, 600)) - 300;
      default: s = ($urandom_range(0, 1) == 1) ? SCORE_TOP : SCORE_BOTTOM;
    endcase
    if (s > SCORE_TOP) s = SCORE_TOP;
    if (s < SCORE_BOTTOM) s = SCORE_BOTTOM;
    return s;
  endfunction

  function automatic int pick_window;
    if ($urandom_range(0, 1) == 1) return int'($signed(16'($urandom)));
    return int'($urandom_range(0, 600)) - 300;
  endfunction

  // Random traffic over a small pool of keys so that stores and probes meet. The
  // keys crowd into a few slots, which makes tag conflicts and replacement common.
  // A small share of requests uses fully random keys as background noise.
  task automatic random_phase(input int count);
    logic [HASH_W-1:0]   pool [POOL_KEYS];
    logic [IDX_BITS-1:0] slots [POOL_SLOTS];
    logic [HASH_W-1:0]   key;
    logic                cmd;
    logic [KIND_W-1:0]   kind;
    int                  ply;
    int                  depth;
    foreach (slots[i]) slots[i] = IDX_BITS'($urandom_range(0, TABLE_ENTRIES - 1));
    if ($urandom_range(0, 1) == 1) slots[0] = '0;
    if ($urandom_range(0, 1) == 1) slots[1] = '1;
    foreach (pool[k]) begin
      key = {$urandom, $urandom};
      key[IDX_BITS-1:0] = slots[$urandom_range(0, POOL_SLOTS - 1)];
      pool[k] = key;
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) key = {$urandom, $urandom};
      else key = pool[$urandom_range(0, POOL_KEYS - 1)];
      cmd = ($urandom_range(0, 99) < 45) ? CMD_STORE : CMD_PROBE;
      ply = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      if (cmd == CMD_STORE) begin
        depth = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 60);
      end else begin
        depth = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 254) : $urandom_range(0, 30);
      end
      if ($urandom_range(0, 15) == 0) kind = 2'd3;
      else kind = KIND_W'($urandom_range(0, 2));
      send_req(cmd, key, ply, depth, pick_score(), kind, pick_window(), pick_window());
    end
  endtask

  // Directed requests at the reset threshold of 32000.
  task automatic directed_basic;
    // A slot that was never written reads as key zero and depth zero: no hit.
    send_req(CMD_PROBE, '0, 0, 0, 0, KIND_EXACT, 0, 0);
    // Plain exact entry: hit at its own depth, miss when more depth is asked.
    send_req(CMD_STORE, KEY_A, 3, 5, 100, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_A, 3, 5, 0, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_A, 3, 6, 0, KIND_EXACT, 0, 0);
    // An equal depth does not replace, and a store of depth zero never writes.
    send_req(CMD_STORE, KEY_A, 3, 5, 7, KIND_EXACT, 0, 0);
    send_req(CMD_STORE, KEY_B, 0, 0, 42, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_B, 0, 0, 0, KIND_EXACT, 0, 0);
    // Winning mate at the largest ply saturates, gets the maximum depth, and is
    // brought back toward zero on the way out.
    send_req(CMD_STORE, KEY_C, 1023, 1, SCORE_TOP, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_C, 1023, 254, 0, KIND_EXACT, 0, 0);
    // Losing mate at the bottom of the range saturates the other way.
    send_req(CMD_STORE, KEY_D, 1023, 2, SCORE_BOTTOM, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_D, 5, 1, 0, KIND_EXACT, 0, 0);
    // Fail-low entry: usable only when the score is at most alpha.
    send_req(CMD_STORE, KEY_E, 0, 10, 50, KIND_LOW, 0, 0);
    send_req(CMD_PROBE, KEY_E, 0, 10, 0, KIND_EXACT, 50, 0);
    send_req(CMD_PROBE, KEY_E, 0, 10, 0, KIND_EXACT, 49, 0);
    // Fail-high entry: usable only when the score is at least beta.
    send_req(CMD_STORE, KEY_F, 0, 10, -50, KIND_HIGH, 0, 0);
    send_req(CMD_PROBE, KEY_F, 0, 10, 0, KIND_EXACT, 0, -50);
    send_req(CMD_PROBE, KEY_F, 0, 10, 0, KIND_EXACT, 0, -49);
    // The unused bound code is kept as written but never satisfies a probe.
    send_req(CMD_STORE, KEY_G, 0, 3, 1, 2'd3, 0, 0);
    send_req(CMD_PROBE, KEY_G, 0, 1, 0, KIND_EXACT, SCORE_TOP, SCORE_BOTTOM);
    // A deeper store with another tag in the same slot evicts the old key.
    send_req(CMD_STORE, KEY_A2, 0, 9, -300, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_A, 0, 1, 0, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_A2, 0, 9, 0, KIND_EXACT, 0, 0);
    // All-ones key, largest ply, a depth of 254, a score just below the threshold.
    send_req(CMD_STORE, KEY_ONES, 1023, 254, 31999, KIND_HIGH, SCORE_BOTTOM, SCORE_TOP);
    send_req(CMD_PROBE, KEY_ONES, 1023, 254, 0, KIND_EXACT, SCORE_BOTTOM, 31999);
    // A losing score exactly at the threshold counts as a mate.
    send_req(CMD_STORE, KEY_H, 17, 4, -32000, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_H, 17, 4, 0, KIND_EXACT, 0, 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset threshold. The first request waits out the clearing pass on tready.
    directed_basic();
    random_phase(RANDOM_PER_PHASE);

    // Threshold zero: every score is a mate, and zero itself moves down by ply.
    drain();
    write_threshold(32'd0);
    send_req(CMD_STORE, KEY_Z, 7, 1, 0, KIND_EXACT, 0, 0);
    send_req(CMD_PROBE, KEY_Z, 7, 1, 0, KIND_EXACT, 0, 0);
    random_phase(RANDOM_PER_PHASE);

    // Largest threshold: only the very edges of the score range count as mates.
    drain();
    write_threshold(32'd32767);
    random_phase(RANDOM_PER_PHASE);

    // Bits above the register width are dropped, leaving a threshold of one.
    drain();
    write_threshold(32'hA5A5_0000 | 32'd1);
    random_phase(RANDOM_PER_PHASE);

    drain();
    write_threshold(APB_DW'($urandom_range(100, 31000)));
    random_phase(RANDOM_PER_PHASE);

    drain();
    $display("Sent %0d stores and %0d probes across %0d mate threshold settings,",
             n_stores, n_probes, n_settings);
    $display("with %0d slot replacements and %0d probe hits predicted and checked.",
             chk_writes, chk_hits);
    if (chk_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
